### rtl/core/lavm_pkg.sv
// shared types and constants for the look-at view matrix unit
package lavm_pkg;

   localparam int FRAC_BITS = 30;
   localparam int NORM_LAT  = 23;
   localparam int SQRT_LAT  = 8;
   localparam int ROOT_BITS = 32;
   localparam int SQRT_PER  = ROOT_BITS / SQRT_LAT;
   localparam int DIV_LAT   = 8;
   localparam int QUO_BITS  = 32;
   localparam int DIV_PER   = QUO_BITS / DIV_LAT;

   localparam logic REG_NORMAL_MODE = 1'b0;

   typedef enum logic [1:0] {
      ROW_RIGHT = 2'd0,
      ROW_UP    = 2'd1,
      ROW_VIEW  = 2'd2
   } row_sel_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec32_type;

   typedef struct packed {
      vec32_type [2:0]   axis;
      logic [2:0][31:0]  trans;
      logic              degenerate;
   } item_type;

endpackage

### rtl/core/look_at_view_matrix_unit.sv
// look-at view matrix unit: 52 register stages, then a three-row output buffer
// the three rows of each camera follow one a cycle while rsp_stall is low
// the camera rate is set by the single result channel carrying 3 rows per camera
// the pipeline advances as a whole; it holds while its last stage waits on the buffer
// reset clears every valid bit, the output buffer and normal_mode
module look_at_view_matrix_unit import lavm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_col_x,
   output logic signed [31:0] rsp_col_y,
   output logic signed [31:0] rsp_col_z,
   output logic signed [31:0] rsp_translation,
   output logic               rsp_degenerate,
   output logic               rsp_last_row,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int DU_POS = NORM_LAT;
   localparam int V_POS  = 2 * NORM_LAT + 2;
   localparam int LAST   = V_POS + 3;

   logic               normal_mode_ff;
   logic               adv, ser_ready;
   logic [LAST:0]      vld_ff;
   vec32_type          eye_ff [0:V_POS];
   logic signed [32:0] dif_ff [3];
   logic signed [63:0] dvec [3];
   logic signed [63:0] uvec [3];
   vec32_type          d_unit, u_unit, v_unit;
   logic               d_ok, u_ok, v_ok;
   vec32_type          d_dly_ff [DU_POS+1:V_POS];
   vec32_type          u_dly_ff [DU_POS+1:V_POS];
   logic               ok_dly_ff [DU_POS+1:V_POS];
   logic signed [63:0] cp_ff [6];
   logic signed [63:0] vraw_ff [3];
   vec32_type [2:0]    rows_in, rows1_ff, rows2_ff;
   logic signed [63:0] tp_ff [3][3];
   logic signed [63:0] tneg_ff [3];
   logic               ok_in, ok1_ff, ok2_ff;
   item_type           item_in, item_ff;

   function automatic logic [31:0] round_sat(input logic signed [63:0] neg);
      logic [63:0] mag;
      logic [34:0] mg;
      logic [31:0] res;
      mag = neg[63] ? 64'(-neg) : 64'(neg);
      mg  = 35'((mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      if (neg[63]) begin
         res = (mg >= (35'd1 << 31)) ? 32'h8000_0000 : 32'(-mg);
      end else begin
         res = (mg > 35'h7FFF_FFFF) ? 32'h7FFF_FFFF : mg[31:0];
      end
      return res;
   endfunction

   // configuration
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_NORMAL_MODE) ? {31'b0, normal_mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_mode_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr[2] == REG_NORMAL_MODE) begin
         normal_mode_ff <= pwdata[0];
      end
   end

   // whole pipeline moves together
   assign adv       = !vld_ff[LAST] || ser_ready;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         eye_ff[0].x <= req_eye_x;
         eye_ff[0].y <= req_eye_y;
         eye_ff[0].z <= req_eye_z;
         dif_ff[0]   <= 33'(req_target_x) - 33'(req_eye_x);
         dif_ff[1]   <= 33'(req_target_y) - 33'(req_eye_y);
         dif_ff[2]   <= 33'(req_target_z) - 33'(req_eye_z);
         for (int k = 1; k <= V_POS; k++) begin
            eye_ff[k] <= eye_ff[k-1];
         end
      end
   end

   // right axis is up cross view, with up fixed to the y axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvec[i] = 64'(dif_ff[i]);
      end
      uvec[0] = 64'(dif_ff[2]);
      uvec[1] = '0;
      uvec[2] = -64'(dif_ff[0]);
   end

   lavm_norm u_norm_d (
      .clock   (clock),
      .en      (adv),
      .vec_x   (dvec[0]),
      .vec_y   (dvec[1]),
      .vec_z   (dvec[2]),
      .unit    (d_unit),
      .nonzero (d_ok)
   );

   lavm_norm u_norm_u (
      .clock   (clock),
      .en      (adv),
      .vec_x   (uvec[0]),
      .vec_y   (uvec[1]),
      .vec_z   (uvec[2]),
      .unit    (u_unit),
      .nonzero (u_ok)
   );

   // up axis from the exact cross product of the two unit vectors
   always_ff @(posedge clock) begin
      if (adv) begin
         cp_ff[0]   <= d_unit.y * u_unit.z;
         cp_ff[1]   <= d_unit.z * u_unit.y;
         cp_ff[2]   <= d_unit.z * u_unit.x;
         cp_ff[3]   <= d_unit.x * u_unit.z;
         cp_ff[4]   <= d_unit.x * u_unit.y;
         cp_ff[5]   <= d_unit.y * u_unit.x;
         vraw_ff[0] <= cp_ff[0] - cp_ff[1];
         vraw_ff[1] <= cp_ff[2] - cp_ff[3];
         vraw_ff[2] <= cp_ff[4] - cp_ff[5];
         d_dly_ff[DU_POS+1]  <= d_unit;
         u_dly_ff[DU_POS+1]  <= u_unit;
         ok_dly_ff[DU_POS+1] <= d_ok && u_ok;
         for (int k = DU_POS + 2; k <= V_POS; k++) begin
            d_dly_ff[k]  <= d_dly_ff[k-1];
            u_dly_ff[k]  <= u_dly_ff[k-1];
            ok_dly_ff[k] <= ok_dly_ff[k-1];
         end
      end
   end

   lavm_norm u_norm_v (
      .clock   (clock),
      .en      (adv),
      .vec_x   (vraw_ff[0]),
      .vec_y   (vraw_ff[1]),
      .vec_z   (vraw_ff[2]),
      .unit    (v_unit),
      .nonzero (v_ok)
   );

   assign rows_in[0] = u_dly_ff[V_POS];
   assign rows_in[1] = v_unit;
   assign rows_in[2] = d_dly_ff[V_POS];
   assign ok_in      = ok_dly_ff[V_POS] && v_ok;

   // translation: products, negated sum, then round and saturate
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            tp_ff[r][0] <= rows_in[r].x * eye_ff[V_POS].x;
            tp_ff[r][1] <= rows_in[r].y * eye_ff[V_POS].y;
            tp_ff[r][2] <= rows_in[r].z * eye_ff[V_POS].z;
            tneg_ff[r]  <= -(tp_ff[r][0] + tp_ff[r][1] + tp_ff[r][2]);
         end
         rows1_ff <= rows_in;
         ok1_ff   <= ok_in;
         rows2_ff <= rows1_ff;
         ok2_ff   <= ok1_ff;
         item_ff  <= item_in;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         item_in.axis[r]  = ok2_ff ? rows2_ff[r] : '0;
         item_in.trans[r] = (ok2_ff && !normal_mode_ff) ? round_sat(tneg_ff[r]) : '0;
      end
      item_in.degenerate = !ok2_ff;
   end

   lavm_rows u_rows (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (vld_ff[LAST]),
      .in_item         (item_ff),
      .in_ready        (ser_ready),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_row_index   (rsp_row_index),
      .rsp_col_x       (rsp_col_x),
      .rsp_col_y       (rsp_col_y),
      .rsp_col_z       (rsp_col_z),
      .rsp_translation (rsp_translation),
      .rsp_degenerate  (rsp_degenerate),
      .rsp_last_row    (rsp_last_row)
   );

`ifndef SYNTHESIS
   a_row_order : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_row |=>
         rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1)
      else $error("row sequence broken after a transfer");

   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_col_x == 0 && rsp_col_y == 0 && rsp_col_z == 0 && rsp_translation == 0)
      else $error("degenerate row carries non-zero data");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && !ser_ready |=> $stable(vld_ff))
      else $error("pipeline valid bits moved while held");
`endif

endmodule

### rtl/core/lavm_sqrt.sv
// pipelined integer square root, four result bits per stage
module lavm_sqrt import lavm_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root,
   output logic [34:0] rem
);

   logic [63:0] rad_ff  [SQRT_LAT];
   logic [31:0] root_ff [SQRT_LAT];
   logic [34:0] rem_ff  [SQRT_LAT];
   logic [63:0] rad_in  [SQRT_LAT];
   logic [31:0] root_in [SQRT_LAT];
   logic [34:0] rem_in  [SQRT_LAT];

   always_comb begin
      logic [63:0] rad_w;
      logic [31:0] root_w;
      logic [34:0] rem_w;
      logic [34:0] trial;
      for (int s = 0; s < SQRT_LAT; s++) begin
         if (s == 0) begin
            rad_w  = rad;
            root_w = '0;
            rem_w  = '0;
         end else begin
            rad_w  = rad_ff[s-1];
            root_w = root_ff[s-1];
            rem_w  = rem_ff[s-1];
         end
         for (int k = 0; k < SQRT_PER; k++) begin
            rem_w = {rem_w[32:0], rad_w[63:62]};
            rad_w = {rad_w[61:0], 2'b00};
            trial = {1'b0, root_w, 2'b01};
            if (rem_w >= trial) begin
               rem_w  = rem_w - trial;
               root_w = {root_w[30:0], 1'b1};
            end else begin
               root_w = {root_w[30:0], 1'b0};
            end
         end
         rad_in[s]  = rad_w;
         root_in[s] = root_w;
         rem_in[s]  = rem_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SQRT_LAT; s++) begin
            rad_ff[s]  <= rad_in[s];
            root_ff[s] <= root_in[s];
            rem_ff[s]  <= rem_in[s];
         end
      end
   end

   assign root = root_ff[SQRT_LAT-1];
   assign rem  = rem_ff[SQRT_LAT-1];

endmodule

### rtl/core/lavm_div.sv
// pipelined restoring divider, four quotient bits per stage
module lavm_div import lavm_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [61:0] num,
   input  logic [31:0] den,
   output logic [31:0] quo
);

   logic [31:0] lo_ff  [DIV_LAT];
   logic [31:0] rem_ff [DIV_LAT];
   logic [31:0] q_ff   [DIV_LAT];
   logic [31:0] den_ff [DIV_LAT];
   logic [31:0] lo_in  [DIV_LAT];
   logic [31:0] rem_in [DIV_LAT];
   logic [31:0] q_in   [DIV_LAT];

   always_comb begin
      logic [31:0] lo_w;
      logic [31:0] rem_w;
      logic [31:0] q_w;
      logic [31:0] den_w;
      logic [32:0] work;
      for (int s = 0; s < DIV_LAT; s++) begin
         if (s == 0) begin
            lo_w  = num[31:0];
            rem_w = {2'b00, num[61:32]};
            q_w   = '0;
            den_w = den;
         end else begin
            lo_w  = lo_ff[s-1];
            rem_w = rem_ff[s-1];
            q_w   = q_ff[s-1];
            den_w = den_ff[s-1];
         end
         for (int k = 0; k < DIV_PER; k++) begin
            work = {rem_w, lo_w[31]};
            lo_w = {lo_w[30:0], 1'b0};
            if (work >= {1'b0, den_w}) begin
               work = work - {1'b0, den_w};
               q_w  = {q_w[30:0], 1'b1};
            end else begin
               q_w  = {q_w[30:0], 1'b0};
            end
            rem_w = work[31:0];
         end
         lo_in[s]  = lo_w;
         rem_in[s] = rem_w;
         q_in[s]   = q_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_LAT; s++) begin
            lo_ff[s]  <= lo_in[s];
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
         end
         den_ff[0] <= den;
         for (int s = 1; s < DIV_LAT; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
      end
   end

   assign quo = q_ff[DIV_LAT-1];

endmodule

### rtl/core/lavm_norm.sv
// vector normaliser to Q2.30: prescale, sum of squares, root, three divides
module lavm_norm import lavm_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] vec_x,
   input  logic signed [63:0] vec_y,
   input  logic signed [63:0] vec_z,
   output vec32_type          unit,
   output logic               nonzero
);

   localparam int SIDE_LAST = NORM_LAT - 1;

   logic signed [63:0] vin [3];
   logic [2:0][63:0] mag1_in, mag1_ff, mag2_ff;
   logic [63:0]      or1_ff;
   logic [2:0]       neg_in;
   logic             nz1_in;
   logic [2:0]       neg_ff [1:SIDE_LAST];
   logic             nz_ff  [1:SIDE_LAST];
   logic [5:0]       pos2_in, pos2_ff;
   logic [2:0][30:0] m3_in, m3_ff, m4_ff, m5_ff;
   logic [2:0][61:0] sq4_in, sq4_ff;
   logic [63:0]      sum5_ff;
   logic [2:0][30:0] mdly_ff [SQRT_LAT];
   logic [31:0]      root;
   logic [34:0]      rem;
   logic [31:0]      len14_in, len14_ff;
   logic [2:0][61:0] num14_in, num14_ff;
   logic [31:0]      quo [3];
   logic [31:0]      res_in [3];
   vec32_type        unit_ff;
   logic             nonzero_ff;

   function automatic logic [5:0] lead_pos(input logic [63:0] val);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (val[i]) p = 6'(i);
      end
      return p;
   endfunction

   assign vin[0] = vec_x;
   assign vin[1] = vec_y;
   assign vin[2] = vec_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i]  = vin[i][63];
         mag1_in[i] = vin[i][63] ? 64'(-vin[i]) : 64'(vin[i]);
      end
      nz1_in  = |(mag1_in[0] | mag1_in[1] | mag1_in[2]);
      pos2_in = lead_pos(or1_ff);
   end

   // bring the largest magnitude to the [2^30, 2^31) window
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos2_ff > 6'(FRAC_BITS)) begin
            m3_in[i] = 31'(mag2_ff[i] >> (pos2_ff - 6'(FRAC_BITS)));
         end else begin
            m3_in[i] = 31'(mag2_ff[i] << (6'(FRAC_BITS) - pos2_ff));
         end
         sq4_in[i] = m3_ff[i] * m3_ff[i];
      end
   end

   // round the root to nearest and build the rounded-quotient numerators
   always_comb begin
      len14_in = root + 32'(rem > 35'(root));
      for (int i = 0; i < 3; i++) begin
         num14_in[i] = {mdly_ff[SQRT_LAT-1][i], 31'b0} >> 1;
         num14_in[i] = num14_in[i] + 62'(len14_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff   <= mag1_in;
         or1_ff    <= mag1_in[0] | mag1_in[1] | mag1_in[2];
         neg_ff[1] <= neg_in;
         nz_ff[1]  <= nz1_in;
         for (int k = 2; k <= SIDE_LAST; k++) begin
            neg_ff[k] <= neg_ff[k-1];
            nz_ff[k]  <= nz_ff[k-1];
         end
         pos2_ff    <= pos2_in;
         mag2_ff    <= mag1_ff;
         m3_ff      <= m3_in;
         sq4_ff     <= sq4_in;
         m4_ff      <= m3_ff;
         sum5_ff    <= 64'(sq4_ff[0]) + 64'(sq4_ff[1]) + 64'(sq4_ff[2]);
         m5_ff      <= m4_ff;
         mdly_ff[0] <= m5_ff;
         for (int k = 1; k < SQRT_LAT; k++) begin
            mdly_ff[k] <= mdly_ff[k-1];
         end
         len14_ff   <= len14_in;
         num14_ff   <= num14_in;
         unit_ff.x  <= res_in[0];
         unit_ff.y  <= res_in[1];
         unit_ff.z  <= res_in[2];
         nonzero_ff <= nz_ff[SIDE_LAST];
      end
   end

   lavm_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (sum5_ff),
      .root  (root),
      .rem   (rem)
   );

   for (genvar g = 0; g < 3; g++) begin : g_div
      lavm_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num14_ff[g]),
         .den   (len14_ff),
         .quo   (quo[g])
      );
   end

   // zero vector divides by zero, so force the result
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!nz_ff[SIDE_LAST]) begin
            res_in[i] = '0;
         end else if (neg_ff[SIDE_LAST][i]) begin
            res_in[i] = -quo[i];
         end else begin
            res_in[i] = quo[i];
         end
      end
   end

   assign unit    = unit_ff;
   assign nonzero = nonzero_ff;

endmodule

### rtl/core/lavm_rows.sv
// result buffer that hands out the three matrix rows of one camera
module lavm_rows import lavm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  item_type           in_item,
   output logic               in_ready,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_col_x,
   output logic signed [31:0] rsp_col_y,
   output logic signed [31:0] rsp_col_z,
   output logic signed [31:0] rsp_translation,
   output logic               rsp_degenerate,
   output logic               rsp_last_row
);

   logic        busy_ff, busy_in;
   row_sel_type row_ff, row_in;
   item_type    item_ff;
   logic        xfer, done, load;
   vec32_type   sel_axis;
   logic [31:0] sel_trans;

   assign xfer     = busy_ff && !rsp_stall;
   assign done     = xfer && (row_ff == ROW_VIEW);
   assign in_ready = !busy_ff || done;
   assign load     = in_valid && in_ready;

   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      if (load) begin
         busy_in = 1'b1;
         row_in  = ROW_RIGHT;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (xfer) begin
         case (row_ff)
            ROW_RIGHT: row_in = ROW_UP;
            ROW_UP:    row_in = ROW_VIEW;
            default:   row_in = ROW_RIGHT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= ROW_RIGHT;
      end else begin
         busy_ff <= busy_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   always_comb begin
      case (row_ff)
         ROW_RIGHT: begin
            sel_axis  = item_ff.axis[0];
            sel_trans = item_ff.trans[0];
         end
         ROW_UP: begin
            sel_axis  = item_ff.axis[1];
            sel_trans = item_ff.trans[1];
         end
         ROW_VIEW: begin
            sel_axis  = item_ff.axis[2];
            sel_trans = item_ff.trans[2];
         end
         default: begin
            sel_axis  = item_ff.axis[0];
            sel_trans = item_ff.trans[0];
         end
      endcase
   end

   assign rsp_valid       = busy_ff;
   assign rsp_row_index   = row_ff;
   assign rsp_col_x       = sel_axis.x;
   assign rsp_col_y       = sel_axis.y;
   assign rsp_col_z       = sel_axis.z;
   assign rsp_translation = sel_trans;
   assign rsp_degenerate  = item_ff.degenerate;
   assign rsp_last_row    = (row_ff == ROW_VIEW);

endmodule

### tb/look_at_view_matrix_unit_test.sv
// self-checking testbench for the look-at view matrix unit
module look_at_view_matrix_unit_test import lavm_pkg::*;;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 70;
   localparam int RANDOM_ITEMS = 300;

   typedef struct packed {
      logic [1:0]         row;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [31:0] tr;
      logic               degen;
      logic               last;
   } matrix_row_type;

   typedef struct packed {
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [31:0] ez;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
   } camera_type;

   typedef enum logic [1:0] {
      EXP_PREDICT,
      EXP_DEGENERATE,
      EXP_LOOK_Z,
      EXP_LOOK_X
   } expect_kind_type;

   typedef struct packed {
      camera_type      cam;
      expect_kind_type kind;
   } stimulus_type;

   localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;
   localparam logic signed [31:0] ONE  = 32'sh0001_0000;
   localparam logic signed [31:0] Q30  = 32'sh4000_0000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_row_index;
   logic signed [31:0] rsp_col_x, rsp_col_y, rsp_col_z, rsp_translation;
   logic               rsp_degenerate, rsp_last_row;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   matrix_row_type expected_rows[$];
   logic           mode_now = 1'b0;
   int             fail_count = 0;
   int             cycle_count = 0;
   int             cameras_sent = 0;
   int             rows_checked = 0;
   int             degenerate_seen = 0;
   int             sender_gap_pct = 0;
   int             receiver_stall_pct = 0;

   look_at_view_matrix_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   // ---------------- predictor ----------------

   function automatic longint unsigned root_nearest(input longint unsigned s0);
      longint unsigned s, r, b;
      s = s0;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (s0 - r * r > r) r = r + 1;
      return r;
   endfunction

   function automatic bit unit_vector(input longint v[3], output longint o[3]);
      longint unsigned m[3], mx, s, len, q;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
         if (m[i] > mx) mx = m[i];
         o[i] = 0;
      end
      if (mx == 0) return 1'b0;
      while (mx >= (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         mx = mx >> 1;
      end
      while (mx < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         mx = mx << 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = root_nearest(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 30) + len / 2) / len;
         o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic logic signed [31:0] eye_offset(input longint r[3], input longint e[3]);
      longint sum, neg;
      longint unsigned mg;
      sum = r[0] * e[0] + r[1] * e[1] + r[2] * e[2];
      neg = -sum;
      mg = ((neg < 0 ? longint'(-neg) : neg) + (64'd1 << 29)) >> 30;
      if (neg < 0) return (mg >= (64'd1 << 31)) ? MINV : -(32'(mg));
      return (mg > 64'h7FFF_FFFF) ? MAXV : 32'(mg);
   endfunction

   task automatic predict_camera(input camera_type c);
      longint e[3], diff[3], d[3], ur[3], u[3], vr[3], v[3], axis[3][3];
      bit ok;
      matrix_row_type r;
      e = '{longint'(c.ex), longint'(c.ey), longint'(c.ez)};
      diff = '{longint'(c.tx) - e[0], longint'(c.ty) - e[1], longint'(c.tz) - e[2]};
      ok = unit_vector(diff, d);
      ur = '{diff[2], 0, -diff[0]};
      ok = unit_vector(ur, u) && ok;
      vr = '{d[1] * u[2] - d[2] * u[1], d[2] * u[0] - d[0] * u[2], d[0] * u[1] - d[1] * u[0]};
      ok = unit_vector(vr, v) && ok;
      axis[0] = u;
      axis[1] = v;
      axis[2] = d;
      for (int k = 0; k < 3; k++) begin
         r.row   = 2'(k);
         r.cx    = ok ? 32'(axis[k][0]) : '0;
         r.cy    = ok ? 32'(axis[k][1]) : '0;
         r.cz    = ok ? 32'(axis[k][2]) : '0;
         r.tr    = (ok && !mode_now) ? eye_offset(axis[k], e) : '0;
         r.degen = !ok;
         r.last  = (k == 2);
         expected_rows.push_back(r);
      end
   endtask

   function automatic matrix_row_type typed_row(input row_sel_type sel,
         input logic signed [31:0] x, y, z, input logic dg);
      matrix_row_type r;
      r = '{row: sel, cx: x, cy: y, cz: z, tr: '0, degen: dg, last: (sel == ROW_VIEW)};
      return r;
   endfunction

   // ---------------- drivers ----------------

   task automatic send_camera(input stimulus_type st);
      int gap;
      req_valid    <= 1'b1;
      req_eye_x    <= st.cam.ex;
      req_eye_y    <= st.cam.ey;
      req_eye_z    <= st.cam.ez;
      req_target_x <= st.cam.tx;
      req_target_y <= st.cam.ty;
      req_target_z <= st.cam.tz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer taken at this edge
      cameras_sent++;
      case (st.kind)
         EXP_DEGENERATE: begin
            expected_rows.push_back(typed_row(ROW_RIGHT, 0, 0, 0, 1'b1));
            expected_rows.push_back(typed_row(ROW_UP, 0, 0, 0, 1'b1));
            expected_rows.push_back(typed_row(ROW_VIEW, 0, 0, 0, 1'b1));
         end
         EXP_LOOK_Z: begin
            expected_rows.push_back(typed_row(ROW_RIGHT, Q30, 0, 0, 1'b0));
            expected_rows.push_back(typed_row(ROW_UP, 0, Q30, 0, 1'b0));
            expected_rows.push_back(typed_row(ROW_VIEW, 0, 0, Q30, 1'b0));
         end
         EXP_LOOK_X: begin
            expected_rows.push_back(typed_row(ROW_RIGHT, 0, 0, -Q30, 1'b0));
            expected_rows.push_back(typed_row(ROW_UP, 0, Q30, 0, 1'b0));
            expected_rows.push_back(typed_row(ROW_VIEW, Q30, 0, 0, 1'b0));
         end
         default: predict_camera(st.cam);
      endcase
      gap = 0;
      while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (expected_rows.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_normal_mode(input logic [31:0] value);
      settle_idle();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= 3'(REG_NORMAL_MODE) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      mode_now = value[0];
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[0] !== mode_now) begin
         $error("normal_mode readback: expected %0d, got %0d", mode_now, prdata[0]);
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] any_coord();
      case ($urandom_range(3))
         0:       return $signed($urandom_range(2 * 65536)) - 65536;
         1:       return $signed($urandom_range(2000)) - 1000;
         2:       return $urandom_range(1) ? MAXV - $urandom_range(3) : MINV + $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   function automatic camera_type random_camera();
      camera_type c;
      c = '{any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord()};
      case ($urandom_range(19))
         0: begin
            c.tx = c.ex;
            c.ty = c.ey;
            c.tz = c.ez;
         end
         1: begin
            c.tx = c.ex;
            c.tz = c.ez;
         end
         2: c.tx = c.ex;
         3: c.tz = c.ez;
         default: ;
      endcase
      return c;
   endfunction

   // ---------------- result check ----------------

   task automatic check_field(input string name, input logic signed [31:0] exp_v, got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      matrix_row_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rows.size() == 0) begin
            $error("row transfer with nothing expected");
            fail_count++;
         end else begin
            e = expected_rows.pop_front();
            check_field("row_index", e.row, rsp_row_index);
            check_field("col_x", e.cx, rsp_col_x);
            check_field("col_y", e.cy, rsp_col_y);
            check_field("col_z", e.cz, rsp_col_z);
            check_field("translation", e.tr, rsp_translation);
            check_field("degenerate", e.degen, rsp_degenerate);
            check_field("last_row", e.last, rsp_last_row);
            rows_checked++;
            if (rsp_degenerate) degenerate_seen++;
         end
      end
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("timeout after %0d cycles, %0d rows outstanding", cycle_count,
               expected_rows.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------- stimulus ----------------

   stimulus_type directed[] = '{
      '{'{0, 0, 0, 0, 0, 0}, EXP_DEGENERATE},
      '{'{MAXV, MINV, MAXV, MAXV, MINV, MAXV}, EXP_DEGENERATE},
      '{'{0, 0, 0, 0, 5 * ONE, 0}, EXP_DEGENERATE},
      '{'{ONE, MAXV, -ONE, ONE, MINV, -ONE}, EXP_DEGENERATE},
      '{'{0, 0, 0, 0, 0, ONE}, EXP_LOOK_Z},
      '{'{0, 0, 0, ONE, 0, 0}, EXP_LOOK_X},
      '{'{0, 0, 0, 0, 7 * ONE, 1}, EXP_PREDICT},
      '{'{MINV, MINV, MINV, MAXV, MAXV, MAXV}, EXP_PREDICT},
      '{'{MAXV, MAXV, MAXV, MINV, MINV, MINV}, EXP_PREDICT},
      '{'{MAXV, MAXV, MAXV, 0, 0, 0}, EXP_PREDICT},
      '{'{MINV, MINV, MINV, 0, 0, 0}, EXP_PREDICT},
      '{'{MAXV, 0, MINV, MINV, 0, MAXV}, EXP_PREDICT},
      '{'{3 * ONE, 2 * ONE, -4 * ONE, -ONE, -ONE, 2 * ONE}, EXP_PREDICT},
      '{'{0, 0, 0, -1, -1, -1}, EXP_PREDICT},
      '{'{0, 0, 0, 1, 0, -1}, EXP_PREDICT},
      '{'{32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F,
          32'shF0F0_F0F0, 32'sh5555_5555, 32'shAAAA_AAAA}, EXP_PREDICT},
      '{'{ONE, ONE, ONE, ONE, 0, ONE + 1}, EXP_PREDICT},
      '{'{-ONE, 100 * ONE, 0, ONE, -100 * ONE, 0}, EXP_PREDICT}
   };

   initial begin
      int seg;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // only bit 0 of the written word should matter
      set_normal_mode(32'hFFFF_FFFE);
      foreach (directed[i]) send_camera(directed[i]);
      set_normal_mode(32'h0000_0001);
      foreach (directed[i]) send_camera('{directed[i].cam, EXP_PREDICT});

      for (seg = 0; seg < 6; seg++) begin
         set_normal_mode(32'(seg % 2));
         case (seg / 2)
            0: begin
               sender_gap_pct = 11;
               receiver_stall_pct = 87;
            end
            1: begin
               sender_gap_pct = 87;
               receiver_stall_pct = 11;
            end
            default: begin
               sender_gap_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
            // hold back once mid-run until the pipeline has emptied
            if (seg == 4 && n == 20) settle_idle();
            send_camera('{random_camera(), EXP_PREDICT});
         end
      end
      req_valid <= 1'b0;
      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      wait (expected_rows.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d cameras sent, %0d rows checked (%0d degenerate), both matrix modes,",
               cameras_sent, rows_checked, degenerate_seen);
      $display("under sender gaps, receiver stalls and full-rate stretches");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
